@@ src/lfu_pkg.sv @@
`timescale 1ns / 1ps

package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int CAP_W          = 5;
  localparam int DATA_W         = 32;

  // Operation broadcast from the controller to every cell.
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_BUMP   = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_EVICT  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       put;
  } lfu_ctl_t;

endpackage

@@ src/lfu_cell.sv @@
`timescale 1ns / 1ps

module lfu_cell import lfu_pkg::*; #(
  parameter int IDXW = 4,
  parameter int CW   = 16,
  parameter int IDX  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lfu_ctl_t          ctl,
  input  logic              sel,
  input  logic [IDXW-1:0]   ref_rank,
  input  logic [DATA_W-1:0] lkey,
  input  logic [DATA_W-1:0] wr_value,
  output logic              match,
  output logic              valid_o,
  output logic [DATA_W-1:0] key_o,
  output logic [DATA_W-1:0] value_o,
  output logic [IDXW-1:0]   rank_o,
  input  logic              best_found_i,
  input  logic [CW-1:0]     best_cnt_i,
  input  logic [IDXW-1:0]   best_rank_i,
  input  logic [IDXW-1:0]   best_idx_i,
  output logic              best_found_o,
  output logic [CW-1:0]     best_cnt_o,
  output logic [IDXW-1:0]   best_rank_o,
  output logic [IDXW-1:0]   best_idx_o
);

  logic              valid_r, valid_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] value_r, value_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [IDXW-1:0]   rank_r, rank_nxt;
  logic              take;

  assign match   = valid_r && (key_r == lkey);
  assign valid_o = valid_r;
  assign key_o   = key_r;
  assign value_o = value_r;
  assign rank_o  = rank_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    cnt_nxt   = cnt_r;
    rank_nxt  = rank_r;
    unique case (ctl.op)
      OP_BUMP: begin
        if (sel) begin
          if (cnt_r != {CW{1'b1}}) cnt_nxt = cnt_r + 1'b1;
          rank_nxt = '0;
          if (ctl.put) value_nxt = wr_value;
        end else if (valid_r && rank_r < ref_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_INSERT: begin
        if (sel) begin
          valid_nxt = 1'b1;
          key_nxt   = lkey;
          value_nxt = wr_value;
          cnt_nxt   = {{(CW-1){1'b0}}, 1'b1};
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_EVICT: begin
        if (sel) begin
          valid_nxt = 1'b0;
        end else if (valid_r && rank_r > ref_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Victim candidate: lower count wins, on a tie the older entry wins.
  assign take = valid_r && (!best_found_i || cnt_r < best_cnt_i ||
                (cnt_r == best_cnt_i && rank_r > best_rank_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= 1'b0;
      cnt_r        <= '0;
      rank_r       <= '0;
      best_found_o <= 1'b0;
    end else begin
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      rank_r       <= rank_nxt;
      best_found_o <= best_found_i || take;
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
    if (take) begin
      best_cnt_o  <= cnt_r;
      best_rank_o <= rank_r;
      best_idx_o  <= IDXW'(IDX);
    end else begin
      best_cnt_o  <= best_cnt_i;
      best_rank_o <= best_rank_i;
      best_idx_o  <= best_idx_i;
    end
  end

endmodule

@@ src/lfu_cache_table_top.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Signals                                   | Handshake
// in_     | request   | in_command, in_key, in_value              | in_valid / in_stall
// out_    | result    | out_hit, out_read_value, out_evicted,     | out_valid / out_stall
//         |           | out_evicted_key                           |
// cfg_    | register  | cfg_data (capacity)                       | cfg_valid / cfg_ready
//
// One request is worked at a time. A get that hits or a put that updates runs the lookup
// and a bump step; a get miss or a put at zero capacity goes from the lookup straight to
// the result. A put of a new key runs an insert step, and when the store is full first a
// victim search that walks the row of cells one cell per cycle and an eviction step. The
// next request is accepted in the cycle after the result register loads.
// Reset is synchronous and active low; it empties the store and sets capacity to 16.
// A waiting result does not block acceptance of the next request, which then holds
// in its final step until the result register is free.
module lfu_cache_table_top import lfu_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic signed [DATA_W-1:0] in_key,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_hit,
  output logic signed [DATA_W-1:0] out_read_value,
  output logic                     out_evicted,
  output logic signed [DATA_W-1:0] out_evicted_key,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_W-1:0]         cfg_data
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int CMPW = (CNTW > CAP_W) ? CNTW : CAP_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOK   = 3'd1;
  localparam logic [2:0] S_BUMP   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_EVICT  = 3'd4;
  localparam logic [2:0] S_INSERT = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [CAP_W-1:0]  cap_r;
  logic              cmd_r;
  logic [DATA_W-1:0] key_r, val_r;
  logic [ENTRIES-1:0] sel_r, sel_nxt;
  logic [IDXW-1:0]   ref_r, ref_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic [CNTW-1:0]   scan_r, scan_nxt;
  logic              res_hit_r, res_hit_nxt, res_ev_r, res_ev_nxt;
  logic [DATA_W-1:0] res_rd_r, res_rd_nxt, res_evk_r, res_evk_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_rd_r, out_evk_r;
  logic              out_hit_r, out_ev_r;

  lfu_ctl_t           ctl;
  logic [ENTRIES-1:0] cell_sel, match_v, valid_v, free_v, free_one;
  logic [DATA_W-1:0]  cell_key [ENTRIES];
  logic [DATA_W-1:0]  cell_val [ENTRIES];
  logic [IDXW-1:0]    cell_rank [ENTRIES];
  logic [DATA_W-1:0]  hit_val, sel_key;
  logic [IDXW-1:0]    hit_rank, sel_rank;
  logic [IDXW-1:0]    ref_bcast;
  logic [CMPW-1:0]    cap_eff, count_ext;
  logic               load_out;

  logic              ch_found [ENTRIES+1];
  logic [COUNT_BITS-1:0] ch_cnt [ENTRIES+1];
  logic [IDXW-1:0]   ch_rank [ENTRIES+1];
  logic [IDXW-1:0]   ch_idx [ENTRIES+1];

  assign ch_found[0] = 1'b0;
  assign ch_cnt[0]   = '0;
  assign ch_rank[0]  = '0;
  assign ch_idx[0]   = '0;

  // The row of entry cells; the victim search ripples from cell 0 upward.
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lfu_cell #(.IDXW(IDXW), .CW(COUNT_BITS), .IDX(g)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .sel          (cell_sel[g]),
      .ref_rank     (ref_bcast),
      .lkey         (key_r),
      .wr_value     (val_r),
      .match        (match_v[g]),
      .valid_o      (valid_v[g]),
      .key_o        (cell_key[g]),
      .value_o      (cell_val[g]),
      .rank_o       (cell_rank[g]),
      .best_found_i (ch_found[g]),
      .best_cnt_i   (ch_cnt[g]),
      .best_rank_i  (ch_rank[g]),
      .best_idx_i   (ch_idx[g]),
      .best_found_o (ch_found[g+1]),
      .best_cnt_o   (ch_cnt[g+1]),
      .best_rank_o  (ch_rank[g+1]),
      .best_idx_o   (ch_idx[g+1])
    );
  end

  // Keys are unique among valid entries, so an OR over the matching cells
  // yields the single hit entry's fields.
  always_comb begin
    hit_val  = '0;
    hit_rank = '0;
    sel_key  = '0;
    sel_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_v[i]) begin
        hit_val  = hit_val | cell_val[i];
        hit_rank = hit_rank | cell_rank[i];
      end
      if (sel_r[i]) begin
        sel_key  = sel_key | cell_key[i];
        sel_rank = sel_rank | cell_rank[i];
      end
    end
  end

  // Lowest free slot as a one-hot vector.
  assign free_v   = ~valid_v;
  assign free_one = free_v & (~free_v + 1'b1);

  assign cap_eff   = (CMPW'(cap_r) > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : CMPW'(cap_r);
  assign count_ext = CMPW'(count_r);

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    ref_nxt     = ref_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    res_hit_nxt = res_hit_r;
    res_rd_nxt  = res_rd_r;
    res_ev_nxt  = res_ev_r;
    res_evk_nxt = res_evk_r;
    ctl.op      = OP_NONE;
    ctl.put     = cmd_r;
    cell_sel    = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_LOOK;
      end
      S_LOOK: begin
        res_hit_nxt = 1'b0;
        res_rd_nxt  = '0;
        res_ev_nxt  = 1'b0;
        res_evk_nxt = '0;
        scan_nxt    = '0;
        if (cmd_r && cap_r == '0) begin
          state_nxt = S_DONE;
        end else if (|match_v) begin
          res_hit_nxt = 1'b1;
          res_rd_nxt  = cmd_r ? '0 : hit_val;
          sel_nxt     = match_v;
          ref_nxt     = hit_rank;
          state_nxt   = S_BUMP;
        end else if (!cmd_r) begin
          res_rd_nxt = '1;
          state_nxt  = S_DONE;
        end else if (count_ext >= cap_eff) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_BUMP: begin
        ctl.op    = OP_BUMP;
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        scan_nxt = scan_r + 1'b1;
        if (scan_r == CNTW'(ENTRIES - 1)) begin
          for (int i = 0; i < ENTRIES; i++) begin
            sel_nxt[i] = (ch_idx[ENTRIES] == IDXW'(i));
          end
          state_nxt = S_EVICT;
        end
      end
      S_EVICT: begin
        ctl.op      = OP_EVICT;
        res_ev_nxt  = 1'b1;
        res_evk_nxt = sel_key;
        count_nxt   = count_r - 1'b1;
        state_nxt   = S_INSERT;
      end
      S_INSERT: begin
        ctl.op    = OP_INSERT;
        cell_sel  = free_one;
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (state_r == S_EVICT) ref_nxt = sel_rank;
  end

  // The eviction needs the victim's rank at the time of the broadcast; it is
  // taken directly from the selected cell in the same cycle.
  assign ref_bcast = (state_r == S_EVICT) ? sel_rank : ref_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= CAP_W'(16);
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (load_out) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
    if (state_r == S_IDLE && in_valid) begin
      cmd_r <= in_command;
      key_r <= in_key;
      val_r <= in_value;
    end
    sel_r     <= sel_nxt;
    ref_r     <= ref_nxt;
    scan_r    <= scan_nxt;
    res_hit_r <= res_hit_nxt;
    res_rd_r  <= res_rd_nxt;
    res_ev_r  <= res_ev_nxt;
    res_evk_r <= res_evk_nxt;
    if (load_out) begin
      out_hit_r <= res_hit_r;
      out_rd_r  <= res_rd_r;
      out_ev_r  <= res_ev_r;
      out_evk_r <= res_evk_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

endmodule

@@ src/lfu_checker.sv @@
`timescale 1ns / 1ps

module lfu_checker import lfu_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic              out_hit,
  input logic [DATA_W-1:0] out_read_value,
  input logic              out_evicted,
  input logic [DATA_W-1:0] out_evicted_key
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_evicted_key) && $stable(out_hit))
    else $error("stalled result changed");

  // Only a put of a new key evicts, so it neither hits nor returns data.
  a_ev_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_hit && out_read_value == '0)
    else $error("eviction reported with a hit or data");

  a_evk_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_key == '0)
    else $error("evicted key without eviction");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind lfu_cache_table_top lfu_checker u_lfu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_hit         (out_hit),
  .out_read_value  (out_read_value),
  .out_evicted     (out_evicted),
  .out_evicted_key (out_evicted_key)
);
